### hw/rtl/generations_cellular_automaton_3d_assert.svh
`ifndef GENERATIONS_CELLULAR_AUTOMATON_3D_ASSERT_SVH
`define GENERATIONS_CELLULAR_AUTOMATON_3D_ASSERT_SVH

// same-cycle implication
`define GCA_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GCA_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/gca_pkg.sv
package gca_pkg;

   localparam int GRID_SIDE_DEF = 32;

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 5;
   localparam int STATE_W    = 8;
   localparam int COUNT_W    = 5;
   localparam int MASK_W     = 27;
   localparam int GSIDE_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;
   localparam logic [COUNT_W-1:0] COUNT_LIM  = 5'd27;
   localparam logic [4:0]         CENTRE_IDX = 5'd13;

   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIDE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_D     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BORN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SURVIVE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NBH       = 3'd5;

   localparam logic [GSIDE_W-1:0] GRID_SIDE_RST = 6'd32;
   localparam logic [STATE_W-1:0] DECAY_RST     = 8'd1;
   localparam logic [MASK_W-1:0]  BORN_RST      = 27'd8;
   localparam logic [MASK_W-1:0]  SURVIVE_RST   = 27'd12;
   localparam logic [MASK_W-1:0]  NBH_RST       = 27'd134209535;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               in_range;
   } cmd_type;

   typedef struct packed {
      logic [STATE_W-1:0] cell_state;
      logic [COUNT_W-1:0] neighbour_count;
      logic               changed;
   } rsp_type;

   typedef struct packed {
      logic               two_d;
      logic [STATE_W-1:0] full_state;
      logic [MASK_W-1:0]  born_mask;
      logic [MASK_W-1:0]  survive_mask;
      logic [MASK_W-1:0]  nbh_mask;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic rebuild;
   } maint_type;

   typedef enum logic [1:0] {
      OP_STEP,
      OP_REBUILD,
      OP_EDIT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_REB_SWEEP,
      ST_SNAP_SWEEP,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_TOUCH_RD,
      ST_TOUCH_WR,
      ST_EDIT_RD,
      ST_EDIT_EVAL,
      ST_RESP_RD,
      ST_RESP_PUSH
   } back_state_type;

endpackage

### hw/rtl/gca_front.sv
module gca_front #(
   parameter int GRID_SIDE = gca_pkg::GRID_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(GRID_SIDE+1)-1:0]    side,
   input  logic [$clog2(GRID_SIDE+1)-1:0]    depth,
   input  logic                              two_d,
   input  logic                              clearing,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [gca_pkg::CMD_W-1:0]         req_command,
   input  logic [gca_pkg::COORD_W-1:0]       req_x_coord,
   input  logic [gca_pkg::COORD_W-1:0]       req_y_coord,
   input  logic [gca_pkg::COORD_W-1:0]       req_z_coord,
   output logic                              cq_valid,
   output gca_pkg::cmd_type                  cq_item,
   input  logic                              cq_pop
);

   gca_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   logic       take;
   logic [gca_pkg::COORD_W-1:0] z_eff;
   gca_pkg::cmd_type item;

   // z is forced to the base plane in 2d mode
   assign z_eff = two_d ? '0 : req_z_coord;

   always_comb begin
      item.command  = req_command;
      item.x        = req_x_coord;
      item.y        = req_y_coord;
      item.z        = z_eff;
      item.in_range = (req_x_coord < side) && (req_y_coord < side) && (z_eff < depth);
   end

   assign req_full = (cnt_ff == 2'd2) || clearing || reset;
   assign accept   = req_push && !req_full;
   assign cq_valid = (cnt_ff != 2'd0);
   assign take     = cq_pop && cq_valid;
   assign cq_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### hw/rtl/gca_rsp_fifo.sv
module gca_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gca_pkg::rsp_type push_item,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output gca_pkg::rsp_type pop_item
);

   gca_pkg::rsp_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       put;
   logic       take;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign put      = push && !full;
   assign take     = pop && !empty;
   assign pop_item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = put ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, put} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/gca_back.sv
module gca_back #(
   parameter int GRID_SIDE = gca_pkg::GRID_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(GRID_SIDE+1)-1:0]    side,
   input  logic [$clog2(GRID_SIDE+1)-1:0]    depth,
   input  gca_pkg::cfg_type                  cfg,
   input  gca_pkg::maint_type                maint,
   input  logic                              cq_valid,
   input  gca_pkg::cmd_type                  cq_item,
   output logic                              cq_pop,
   input  logic                              rsp_full,
   output logic                              rsp_push,
   output gca_pkg::rsp_type                  rsp_item,
   output logic                              clearing
);

   localparam int CW = $clog2(GRID_SIDE);
   localparam int AW = 3 * CW;
   localparam int NCELL = 1 << AW;
   localparam logic [AW:0] CELL_END = {1'b1, {AW{1'b0}}};

   logic [gca_pkg::STATE_W-1:0] state_mem [NCELL];
   logic [gca_pkg::COUNT_W-1:0] count_mem [NCELL];
   logic [gca_pkg::COUNT_W-1:0] snap_mem  [NCELL];

   logic [gca_pkg::STATE_W-1:0] state_rd_ff;
   logic [gca_pkg::COUNT_W-1:0] count_rd_ff;
   logic [gca_pkg::COUNT_W-1:0] snap_rd_ff;

   gca_pkg::back_state_type state_ff, state_in;
   gca_pkg::op_type         op_ff, op_in;
   logic [AW:0]             addr_ff, addr_in;
   logic [gca_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic                    changed_ff, changed_in;
   logic                    use_mem_ff, use_mem_in;
   logic                    up_ff, up_in;
   logic [1:0]              dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [AW-1:0]           naddr_ff, naddr_in;

   // memory controls
   logic                        st_re, st_we, cn_re, cn_we, sn_re, sn_we;
   logic [AW-1:0]               st_raddr, st_waddr, cn_raddr, cn_waddr, sn_raddr, sn_waddr;
   logic [gca_pkg::STATE_W-1:0] st_wdata;
   logic [gca_pkg::COUNT_W-1:0] cn_wdata, sn_wdata;

   logic [AW-1:0] addr_lo, prev_addr, edit_addr, naddr;
   logic [CW-1:0] cx, cy, cz, nx, ny, nz;
   logic [CW:0]   nxw, nyw, nzw;
   logic          in_grid, sweep_done, tvalid, touch_last;
   logic [4:0]    kidx;
   logic [31:0]   born32, surv32;
   logic [gca_pkg::STATE_W-1:0] st;
   logic [gca_pkg::COUNT_W-1:0] n;
   logic          born_ok, surv_ok, is_full;
   logic [gca_pkg::COUNT_W-1:0] cnt_upd;

   assign addr_lo    = addr_ff[AW-1:0];
   assign prev_addr  = addr_lo - 1'b1;
   assign cx         = addr_lo[CW-1:0];
   assign cy         = addr_lo[2*CW-1:CW];
   assign cz         = addr_lo[3*CW-1:2*CW];
   assign in_grid    = (cx < side) && (cy < side) && (cz < depth);
   assign sweep_done = (addr_ff == CELL_END);
   assign edit_addr  = {CW'(cq_item.z), CW'(cq_item.y), CW'(cq_item.x)};

   // neighbour walk
   assign nxw  = (CW+1)'(cx) + (CW+1)'(dx_ff);
   assign nyw  = (CW+1)'(cy) + (CW+1)'(dy_ff);
   assign nzw  = (CW+1)'(cz) + (CW+1)'(dz_ff);
   assign nx   = CW'(nxw - 1'b1);
   assign ny   = CW'(nyw - 1'b1);
   assign nz   = CW'(nzw - 1'b1);
   assign kidx = 5'(dx_ff) + 5'(dy_ff) * 5'd3 + 5'(dz_ff) * 5'd9;
   assign naddr = {nz, ny, nx};
   assign tvalid = (kidx != gca_pkg::CENTRE_IDX) && cfg.nbh_mask[kidx]
                   && (nxw != '0) && ((nxw - 1'b1) < side)
                   && (nyw != '0) && ((nyw - 1'b1) < side)
                   && (nzw != '0) && ((nzw - 1'b1) < depth);
   assign touch_last = (dx_ff == 2'd2) && (dy_ff == 2'd2) && (dz_ff == 2'd2);

   // cell rule
   assign st      = state_rd_ff;
   assign n       = snap_rd_ff;
   assign born32  = {5'b0, cfg.born_mask};
   assign surv32  = {5'b0, cfg.survive_mask};
   assign is_full = (st == cfg.full_state);
   assign born_ok = (n != '0) && (n < gca_pkg::COUNT_LIM) && born32[n];
   assign surv_ok = (n < gca_pkg::COUNT_LIM) && surv32[n];

   always_comb begin
      if (up_ff) begin
         cnt_upd = (count_rd_ff == gca_pkg::COUNT_MAX) ? count_rd_ff : count_rd_ff + 1'b1;
      end else begin
         cnt_upd = (count_rd_ff == '0) ? count_rd_ff : count_rd_ff - 1'b1;
      end
   end

   assign clearing = (state_ff == gca_pkg::ST_CLEAR);

   // next state
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      addr_in    = addr_ff;
      cmd_in     = cmd_ff;
      changed_in = changed_ff;
      use_mem_in = use_mem_ff;
      up_in      = up_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      dz_in      = dz_ff;
      naddr_in   = naddr_ff;
      unique case (state_ff)
         gca_pkg::ST_IDLE: begin
            if (cq_valid && !rsp_full) begin
               if (cq_item.command == gca_pkg::CMD_STEP) begin
                  state_in = gca_pkg::ST_SNAP_SWEEP;
                  op_in    = gca_pkg::OP_STEP;
                  addr_in  = '0;
               end else if (!cq_item.in_range) begin
                  state_in   = gca_pkg::ST_RESP_PUSH;
                  use_mem_in = 1'b0;
                  changed_in = 1'b0;
               end else begin
                  state_in = gca_pkg::ST_EDIT_RD;
                  op_in    = gca_pkg::OP_EDIT;
                  cmd_in   = cq_item.command;
                  addr_in  = {1'b0, edit_addr};
               end
            end
         end
         gca_pkg::ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_lo == '1) begin
               state_in = gca_pkg::ST_IDLE;
            end
         end
         gca_pkg::ST_REB_SWEEP: begin
            if (sweep_done) begin
               state_in = gca_pkg::ST_SCAN_RD;
               op_in    = gca_pkg::OP_REBUILD;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         gca_pkg::ST_SNAP_SWEEP: begin
            if (sweep_done) begin
               state_in = gca_pkg::ST_SCAN_RD;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         gca_pkg::ST_SCAN_RD: begin
            if (sweep_done) begin
               if (op_ff == gca_pkg::OP_STEP) begin
                  state_in   = gca_pkg::ST_RESP_PUSH;
                  use_mem_in = 1'b0;
                  changed_in = 1'b1;
               end else begin
                  state_in = gca_pkg::ST_IDLE;
               end
            end else if (in_grid) begin
               state_in = gca_pkg::ST_SCAN_EVAL;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         gca_pkg::ST_SCAN_EVAL: begin
            dx_in    = 2'd0;
            dy_in    = 2'd0;
            dz_in    = 2'd0;
            state_in = gca_pkg::ST_SCAN_RD;
            addr_in  = addr_ff + 1'b1;
            if (op_ff == gca_pkg::OP_REBUILD) begin
               if (st != '0) begin
                  state_in = gca_pkg::ST_TOUCH_RD;
                  addr_in  = addr_ff;
                  up_in    = 1'b1;
               end
            end else if (st == '0) begin
               if (born_ok) begin
                  state_in = gca_pkg::ST_TOUCH_RD;
                  addr_in  = addr_ff;
                  up_in    = 1'b1;
               end
            end else if (is_full && !surv_ok) begin
               state_in = gca_pkg::ST_TOUCH_RD;
               addr_in  = addr_ff;
               up_in    = 1'b0;
            end
         end
         gca_pkg::ST_TOUCH_RD, gca_pkg::ST_TOUCH_WR: begin
            if ((state_ff == gca_pkg::ST_TOUCH_RD) && tvalid) begin
               state_in = gca_pkg::ST_TOUCH_WR;
               naddr_in = naddr;
            end else if (touch_last) begin
               if (op_ff == gca_pkg::OP_EDIT) begin
                  state_in = gca_pkg::ST_RESP_RD;
               end else begin
                  state_in = gca_pkg::ST_SCAN_RD;
                  addr_in  = addr_ff + 1'b1;
               end
            end else begin
               state_in = gca_pkg::ST_TOUCH_RD;
               if (dx_ff != 2'd2) begin
                  dx_in = dx_ff + 1'b1;
               end else begin
                  dx_in = 2'd0;
                  if (dy_ff != 2'd2) begin
                     dy_in = dy_ff + 1'b1;
                  end else begin
                     dy_in = 2'd0;
                     dz_in = dz_ff + 1'b1;
                  end
               end
            end
         end
         gca_pkg::ST_EDIT_RD: begin
            state_in = gca_pkg::ST_EDIT_EVAL;
         end
         gca_pkg::ST_EDIT_EVAL: begin
            use_mem_in = 1'b1;
            changed_in = 1'b0;
            state_in   = gca_pkg::ST_RESP_RD;
            dx_in      = 2'd0;
            dy_in      = 2'd0;
            dz_in      = 2'd0;
            case (cmd_ff)
               gca_pkg::CMD_SET: begin
                  if (st == '0) begin
                     changed_in = 1'b1;
                     up_in      = 1'b1;
                     state_in   = gca_pkg::ST_TOUCH_RD;
                  end
               end
               gca_pkg::CMD_CLEAR: begin
                  if (st != '0) begin
                     changed_in = 1'b1;
                     if (is_full) begin
                        up_in    = 1'b0;
                        state_in = gca_pkg::ST_TOUCH_RD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         gca_pkg::ST_RESP_RD: begin
            state_in = gca_pkg::ST_RESP_PUSH;
         end
         gca_pkg::ST_RESP_PUSH: begin
            state_in = gca_pkg::ST_IDLE;
         end
      endcase
      // maintenance restarts whatever runs, but a rebuild never interrupts a clearing pass
      if (maint.clear) begin
         state_in = gca_pkg::ST_CLEAR;
         addr_in  = '0;
      end else if (maint.rebuild && (state_ff != gca_pkg::ST_CLEAR)) begin
         state_in = gca_pkg::ST_REB_SWEEP;
         addr_in  = '0;
      end
   end

   // outputs
   always_comb begin
      st_re = 1'b0; st_raddr = addr_lo;
      st_we = 1'b0; st_waddr = addr_lo; st_wdata = '0;
      cn_re = 1'b0; cn_raddr = addr_lo;
      cn_we = 1'b0; cn_waddr = addr_lo; cn_wdata = '0;
      sn_re = 1'b0; sn_raddr = addr_lo;
      sn_we = 1'b0; sn_waddr = prev_addr; sn_wdata = count_rd_ff;
      cq_pop   = 1'b0;
      rsp_push = 1'b0;
      rsp_item.cell_state      = use_mem_ff ? state_rd_ff : '0;
      rsp_item.neighbour_count = use_mem_ff ? count_rd_ff : '0;
      rsp_item.changed         = changed_ff;
      unique case (state_ff)
         gca_pkg::ST_IDLE: begin
            cq_pop = cq_valid && !rsp_full;
         end
         gca_pkg::ST_CLEAR: begin
            st_we = 1'b1;
            cn_we = 1'b1;
         end
         gca_pkg::ST_REB_SWEEP: begin
            st_re    = !sweep_done;
            st_we    = (addr_ff != '0);
            st_waddr = prev_addr;
            st_wdata = (state_rd_ff != '0) ? cfg.full_state : '0;
            cn_we    = (addr_ff != '0);
            cn_waddr = prev_addr;
         end
         gca_pkg::ST_SNAP_SWEEP: begin
            cn_re = !sweep_done;
            sn_we = (addr_ff != '0);
         end
         gca_pkg::ST_SCAN_RD: begin
            st_re = !sweep_done && in_grid;
            sn_re = !sweep_done && in_grid;
         end
         gca_pkg::ST_SCAN_EVAL: begin
            if (op_ff == gca_pkg::OP_STEP) begin
               if (st == '0) begin
                  st_we    = born_ok;
                  st_wdata = cfg.full_state;
               end else begin
                  st_we    = !(is_full && surv_ok);
                  st_wdata = st - 1'b1;
               end
            end
         end
         gca_pkg::ST_TOUCH_RD: begin
            cn_re    = tvalid;
            cn_raddr = naddr;
         end
         gca_pkg::ST_TOUCH_WR: begin
            cn_we    = 1'b1;
            cn_waddr = naddr_ff;
            cn_wdata = cnt_upd;
         end
         gca_pkg::ST_EDIT_RD: begin
            st_re = 1'b1;
         end
         gca_pkg::ST_EDIT_EVAL: begin
            case (cmd_ff)
               gca_pkg::CMD_SET: begin
                  st_we    = (st == '0);
                  st_wdata = cfg.full_state;
               end
               gca_pkg::CMD_CLEAR: begin
                  st_we    = (st != '0);
                  st_wdata = '0;
               end
               default: begin
               end
            endcase
         end
         gca_pkg::ST_RESP_RD: begin
            st_re = 1'b1;
            cn_re = 1'b1;
         end
         gca_pkg::ST_RESP_PUSH: begin
            rsp_push = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gca_pkg::ST_CLEAR;
         op_ff    <= gca_pkg::OP_STEP;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      changed_ff <= changed_in;
      use_mem_ff <= use_mem_in;
      up_ff      <= up_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
      naddr_ff   <= naddr_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         state_rd_ff <= state_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cn_we) begin
         count_mem[cn_waddr] <= cn_wdata;
      end
      if (cn_re) begin
         count_rd_ff <= count_mem[cn_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (sn_we) begin
         snap_mem[sn_waddr] <= sn_wdata;
      end
      if (sn_re) begin
         snap_rd_ff <= snap_mem[sn_raddr];
      end
   end

endmodule

### hw/rtl/generations_cellular_automaton_3d.sv
// items: out of range skips the memories; a set or clear across the alive state updates counts
// step: snapshot copy of the counts, then a scan of every cell of the grid,
//   plus neighbour count updates for each cell that enters or leaves the alive state
// throughput: one item at a time through the cell engine; two-entry queues on both sides
// reset: clearing pass over every cell of the built grid, req_full high meanwhile
// grid_side or two_d_mode write repeats the clearing pass; decay or neighbourhood write rebuilds
module generations_cellular_automaton_3d #(
   parameter int GRID_SIDE = gca_pkg::GRID_SIDE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [gca_pkg::CMD_W-1:0]           req_command,
   input  logic [gca_pkg::COORD_W-1:0]         req_x_coord,
   input  logic [gca_pkg::COORD_W-1:0]         req_y_coord,
   input  logic [gca_pkg::COORD_W-1:0]         req_z_coord,
   // result output
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [gca_pkg::STATE_W-1:0]         rsp_cell_state,
   output logic [gca_pkg::COUNT_W-1:0]         rsp_neighbour_count,
   output logic                                rsp_changed,
   // register writes
   input  logic                                csr_we,
   input  logic [gca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gca_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SW = $clog2(GRID_SIDE + 1);

   // configuration registers
   logic [gca_pkg::GSIDE_W-1:0] side_raw_ff;
   logic                        two_d_ff;
   logic [gca_pkg::STATE_W-1:0] decay_ff;
   logic [gca_pkg::MASK_W-1:0]  born_ff;
   logic [gca_pkg::MASK_W-1:0]  survive_ff;
   logic [gca_pkg::MASK_W-1:0]  nbh_ff;

   logic [SW-1:0]      side;
   logic [SW-1:0]      depth;
   gca_pkg::cfg_type   cfg;
   gca_pkg::maint_type maint;

   logic               cq_valid;
   gca_pkg::cmd_type   cq_item;
   logic               cq_pop;
   logic               clearing;
   logic               rsp_full;
   logic               rsp_push;
   gca_pkg::rsp_type   rsp_item;
   gca_pkg::rsp_type   rsp_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_raw_ff <= gca_pkg::GRID_SIDE_RST;
         two_d_ff    <= 1'b0;
         decay_ff    <= gca_pkg::DECAY_RST;
         born_ff     <= gca_pkg::BORN_RST;
         survive_ff  <= gca_pkg::SURVIVE_RST;
         nbh_ff      <= gca_pkg::NBH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            gca_pkg::REG_GRID_SIDE: side_raw_ff <= csr_data[gca_pkg::GSIDE_W-1:0];
            gca_pkg::REG_TWO_D:     two_d_ff    <= csr_data[0];
            gca_pkg::REG_DECAY:     decay_ff    <= csr_data[gca_pkg::STATE_W-1:0];
            gca_pkg::REG_BORN:      born_ff     <= csr_data;
            gca_pkg::REG_SURVIVE:   survive_ff  <= csr_data;
            gca_pkg::REG_NBH:       nbh_ff      <= csr_data;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // side clamped to between two and the built grid, depth collapses to one plane in 2d
   always_comb begin
      if (side_raw_ff < 2) begin
         side = SW'(2);
      end else if (side_raw_ff > GRID_SIDE) begin
         side = SW'(GRID_SIDE);
      end else begin
         side = SW'(side_raw_ff);
      end
      depth = two_d_ff ? SW'(1) : side;
   end

   // decay of zero behaves as one
   always_comb begin
      cfg.two_d        = two_d_ff;
      cfg.full_state   = (decay_ff == '0) ? 8'd1 : decay_ff;
      cfg.born_mask    = born_ff;
      cfg.survive_mask = survive_ff;
      cfg.nbh_mask     = nbh_ff;
   end

   // geometry writes wipe the grid, decay and neighbourhood writes rebuild states and counts
   assign maint.clear   = csr_we && ((csr_index == gca_pkg::REG_GRID_SIDE) ||
                                     (csr_index == gca_pkg::REG_TWO_D));
   assign maint.rebuild = csr_we && ((csr_index == gca_pkg::REG_DECAY) ||
                                     (csr_index == gca_pkg::REG_NBH));

   // front: takes items, checks range, queues them
   gca_front #(
      .GRID_SIDE (GRID_SIDE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .side        (side),
      .depth       (depth),
      .two_d       (two_d_ff),
      .clearing    (clearing),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_command (req_command),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .req_z_coord (req_z_coord),
      .cq_valid    (cq_valid),
      .cq_item     (cq_item),
      .cq_pop      (cq_pop)
   );

   // back: cell engine with the state, count and snapshot memories
   gca_back #(
      .GRID_SIDE (GRID_SIDE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .side     (side),
      .depth    (depth),
      .cfg      (cfg),
      .maint    (maint),
      .cq_valid (cq_valid),
      .cq_item  (cq_item),
      .cq_pop   (cq_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .clearing (clearing)
   );

   // result queue decouples the engine from the consumer
   gca_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_item  (rsp_head)
   );

   assign rsp_cell_state      = rsp_head.cell_state;
   assign rsp_neighbour_count = rsp_head.neighbour_count;
   assign rsp_changed         = rsp_head.changed;

endmodule

### hw/rtl/gca_checker.sv
`include "generations_cellular_automaton_3d_assert.svh"

module gca_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_push,
   input logic                           req_full,
   input logic [gca_pkg::CMD_W-1:0]      req_command,
   input logic [gca_pkg::COORD_W-1:0]    req_x_coord,
   input logic [gca_pkg::COORD_W-1:0]    req_y_coord,
   input logic [gca_pkg::COORD_W-1:0]    req_z_coord,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [gca_pkg::STATE_W-1:0]    rsp_cell_state,
   input logic [gca_pkg::COUNT_W-1:0]    rsp_neighbour_count,
   input logic                           rsp_changed,
   input logic                           csr_we,
   input logic [gca_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [gca_pkg::CSR_DATA_W-1:0] csr_data
);

   // clearing pass holds off input and no result is pending after reset
   `GCA_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, req_full && rsp_empty, "no clearing pass after reset")

   // a grid_side write starts a clearing pass
   `GCA_ASSERT_NEXT(a_geom_clear, clock, reset, csr_we && (csr_index == gca_pkg::REG_GRID_SIDE), req_full, "grid_side write did not clear")

   // counts stay within the 26 neighbours
   `GCA_ASSERT_NOW(a_count_range, clock, reset, !rsp_empty, rsp_neighbour_count <= 5'd26, "neighbour count out of range")

   // a waiting result holds its cell state and changed flag
   `GCA_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_cell_state) && $stable(rsp_changed), "waiting result changed")

endmodule

bind generations_cellular_automaton_3d gca_checker u_gca_checker (.*);

### tb/tb_generations_cellular_automaton_3d.sv
`timescale 1ns / 100ps

module tb_generations_cellular_automaton_3d;
   import gca_pkg::*;

   localparam int SIDE_MAX = 32;
   localparam int CELLS = SIDE_MAX * SIDE_MAX * SIDE_MAX;

   // predicts the automaton and holds the responses still owed by the block
   class life_scoreboard;
      bit [GSIDE_W-1:0] side_reg;
      bit               two_d;
      bit [STATE_W-1:0] decay;
      bit [MASK_W-1:0]  born, survive, nbh;
      bit [STATE_W-1:0] cells [CELLS];
      bit [COUNT_W-1:0] counts [CELLS];
      bit [STATE_W-1:0] snap_st [CELLS];
      bit [COUNT_W-1:0] snap_cnt [CELLS];
      rsp_type          owed [$];
      int               errors;

      function new();
         side_reg = GRID_SIDE_RST;
         two_d    = 1'b0;
         decay    = DECAY_RST;
         born     = BORN_RST;
         survive  = SURVIVE_RST;
         nbh      = NBH_RST;
         errors   = 0;
         wipe();
      endfunction

      function int side_used();
         if (side_reg < 2) return 2;
         if (side_reg > SIDE_MAX) return SIDE_MAX;
         return side_reg;
      endfunction

      function int depth_used();
         return two_d ? 1 : side_used();
      endfunction

      function bit [STATE_W-1:0] alive_val();
         return (decay == 0) ? 8'd1 : decay;
      endfunction

      function int addr(int x, int y, int z);
         return x + SIDE_MAX * (y + SIDE_MAX * z);
      endfunction

      function void wipe();
         foreach (cells[i]) begin
            cells[i]  = '0;
            counts[i] = '0;
         end
      endfunction

      // add or remove one alive neighbour around a cell
      function void touch(int x, int y, int z, bit up);
         int s, d, nx, ny, nz, a;
         s = side_used();
         d = depth_used();
         for (int k = 0; k < 27; k++) begin
            if (k == CENTRE_IDX || !nbh[k]) continue;
            nx = x + k % 3 - 1;
            ny = y + (k / 3) % 3 - 1;
            nz = z + k / 9 - 1;
            if (nx < 0 || ny < 0 || nz < 0 || nx >= s || ny >= s || nz >= d) continue;
            a = addr(nx, ny, nz);
            if (up) begin
               if (counts[a] < COUNT_MAX) counts[a]++;
            end else if (counts[a] > 0) begin
               counts[a]--;
            end
         end
      endfunction

      // every live or decaying cell becomes fully alive, counts recomputed
      function void revive_all();
         int s, d;
         s = side_used();
         d = depth_used();
         foreach (cells[i]) begin
            cells[i]  = (cells[i] != 0) ? alive_val() : 8'd0;
            counts[i] = '0;
         end
         for (int z = 0; z < d; z++)
            for (int y = 0; y < s; y++)
               for (int x = 0; x < s; x++)
                  if (cells[addr(x, y, z)] != 0) touch(x, y, z, 1'b1);
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] val);
         case (idx)
            REG_GRID_SIDE: begin side_reg = val[GSIDE_W-1:0]; wipe(); end
            REG_TWO_D:     begin two_d = val[0]; wipe(); end
            REG_DECAY:     begin decay = val[STATE_W-1:0]; revive_all(); end
            REG_BORN:      born = val;
            REG_SURVIVE:   survive = val;
            REG_NBH:       begin nbh = val; revive_all(); end
            default: ;
         endcase
      endfunction

      function void generation();
         int s, d, c, n;
         bit [STATE_W-1:0] st, full;
         s = side_used();
         d = depth_used();
         full = alive_val();
         foreach (cells[i]) begin
            snap_st[i]  = cells[i];
            snap_cnt[i] = counts[i];
         end
         for (int z = 0; z < d; z++)
            for (int y = 0; y < s; y++)
               for (int x = 0; x < s; x++) begin
                  c  = addr(x, y, z);
                  st = snap_st[c];
                  n  = snap_cnt[c];
                  if (st == 0) begin
                     // zero-count dead cells are never born
                     if (n != 0 && n < COUNT_LIM && born[n]) begin
                        cells[c] = full;
                        touch(x, y, z, 1'b1);
                     end
                  end else if (!(st == full && n < COUNT_LIM && survive[n])) begin
                     cells[c] = st - 8'd1;
                     if (st == full) touch(x, y, z, 1'b0);
                  end
               end
      endfunction

      function void note_item(bit [CMD_W-1:0] cmd, bit [COORD_W-1:0] xi,
                              bit [COORD_W-1:0] yi, bit [COORD_W-1:0] zi);
         rsp_type r;
         int x, y, z, a;
         r = '0;
         x = xi;
         y = yi;
         z = two_d ? 0 : zi;
         if (cmd == CMD_STEP) begin
            generation();
            r.changed = 1'b1;
         end else if (x < side_used() && y < side_used() && z < depth_used()) begin
            a = addr(x, y, z);
            if (cmd == CMD_SET && cells[a] == 0) begin
               cells[a] = alive_val();
               touch(x, y, z, 1'b1);
               r.changed = 1'b1;
            end else if (cmd == CMD_CLEAR && cells[a] != 0) begin
               // a decaying cell leaves the counts alone
               if (cells[a] == alive_val()) touch(x, y, z, 1'b0);
               cells[a] = '0;
               r.changed = 1'b1;
            end
            r.cell_state      = cells[a];
            r.neighbour_count = counts[a];
         end
         owed.insert(owed.size(), r);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch("response with nothing outstanding");
            return;
         end
         want = owed.pop_front();
         if (got.cell_state !== want.cell_state)
            report_mismatch($sformatf("cell_state %0d, want %0d",
                                      got.cell_state, want.cell_state));
         if (got.neighbour_count !== want.neighbour_count)
            report_mismatch($sformatf("neighbour_count %0d, want %0d",
                                      got.neighbour_count, want.neighbour_count));
         if (got.changed !== want.changed)
            report_mismatch($sformatf("changed %0b, want %0b", got.changed, want.changed));
      endtask
   endclass

   logic                  clock, reset;
   logic                  req_push, req_full;
   logic [CMD_W-1:0]      req_command;
   logic [COORD_W-1:0]    req_x_coord, req_y_coord, req_z_coord;
   logic                  rsp_empty, rsp_pop;
   logic [STATE_W-1:0]    rsp_cell_state;
   logic [COUNT_W-1:0]    rsp_neighbour_count;
   logic                  rsp_changed;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   life_scoreboard board;
   int send_idle_pct, pop_stall_pct;

   generations_cellular_automaton_3d DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #40000000;
      $display("generations_cellular_automaton_3d test failed");
      $finish;
   end

   // response side: random stalls, check on every accepted pop
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            board.check_result('{rsp_cell_state, rsp_neighbour_count, rsp_changed});
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // one item through the push side, with an optional random gap first
   task send_item(bit [CMD_W-1:0] cmd, bit [COORD_W-1:0] x, bit [COORD_W-1:0] y,
                  bit [COORD_W-1:0] z);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_command <= cmd;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      do @(posedge clock); while (req_full);
      board.note_item(cmd, x, y, z);
   endtask

   // drain, let the engine settle, then write one register
   task write_csr(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] val);
      req_push <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, val);
   endtask

   task set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      pop_stall_pct = stall_pct;
   endtask

   // random items, mostly edits inside a small grid so patterns can evolve
   task random_items(int n, int step_pct);
      int s, r;
      bit [CMD_W-1:0] cmd;
      s = board.side_used();
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < step_pct) cmd = CMD_STEP;
         else if (r < step_pct + 45) cmd = CMD_SET;
         else if (r < step_pct + 62) cmd = CMD_CLEAR;
         else cmd = CMD_READ;
         if ($urandom_range(9) == 0)
            send_item(cmd, $urandom_range(31), $urandom_range(31), $urandom_range(31));
         else
            send_item(cmd, $urandom_range(s - 1), $urandom_range(s - 1),
                      board.two_d ? $urandom_range(31) : $urandom_range(s - 1));
      end
   endtask

   initial begin
      board       = new();
      reset       = 1'b1;
      req_push    = 1'b0;
      req_command = CMD_READ;
      req_x_coord = '0;
      req_y_coord = '0;
      req_z_coord = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      set_idling(0, 0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings on the full grid
      send_item(CMD_SET, 0, 0, 0);
      send_item(CMD_SET, 0, 0, 0);          // already alive, no change
      send_item(CMD_SET, 31, 31, 31);
      send_item(CMD_SET, 1, 1, 0);
      send_item(CMD_READ, 1, 0, 1);
      send_item(CMD_READ, 30, 30, 30);
      send_item(CMD_CLEAR, 1, 1, 0);
      send_item(CMD_CLEAR, 1, 1, 0);        // already dead
      send_item(CMD_STEP, 31, 0, 0);
      send_item(CMD_READ, 0, 0, 0);

      // small grid clamped from zero, decay chain, everything born and none survive
      write_csr(REG_GRID_SIDE, 0);
      write_csr(REG_DECAY, 3);
      write_csr(REG_BORN, 27'h7FFFFFF);
      write_csr(REG_SURVIVE, 0);
      send_item(CMD_SET, 2, 0, 0);          // outside a side of two
      send_item(CMD_SET, 0, 0, 0);
      send_item(CMD_SET, 1, 1, 1);
      send_item(CMD_STEP, 0, 0, 0);
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_CLEAR, 1, 1, 1);        // clears a decaying cell
      send_item(CMD_READ, 1, 0, 0);
      send_item(CMD_READ, 31, 31, 31);
      write_csr(REG_NBH, 27'h7FFFFFF);      // revives decaying cells
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_STEP, 0, 0, 0);

      // 2d plane, top decay, sparse neighbourhood
      write_csr(REG_TWO_D, 1);
      write_csr(REG_GRID_SIDE, 6);
      write_csr(REG_DECAY, 255);
      write_csr(REG_BORN, 27'h0000008);
      write_csr(REG_SURVIVE, 27'h000000C);
      write_csr(REG_NBH, 27'h00001FF);      // only dz = -1 offsets, all outside in 2d
      set_idling(56, 0);
      random_items(10, 10);
      write_csr(REG_NBH, NBH_RST);
      random_items(20, 8);

      // 3d with a small side, receiver stalls
      write_csr(REG_TWO_D, 0);
      write_csr(REG_GRID_SIDE, 4);
      write_csr(REG_DECAY, 2);
      write_csr(REG_BORN, 27'h0000070);
      write_csr(REG_SURVIVE, 27'h00001F0);
      set_idling(0, 56);
      random_items(30, 8);

      // clamped large side, mask extremes, both sides idle
      write_csr(REG_GRID_SIDE, 63);
      write_csr(REG_BORN, 27'h7FFFFFF);
      write_csr(REG_SURVIVE, 0);
      write_csr(REG_DECAY, 1);
      set_idling(32, 32);
      random_items(8, 0);
      send_item(CMD_STEP, 0, 0, 0);

      // back to a small grid without idling
      write_csr(REG_GRID_SIDE, 3);
      write_csr(REG_NBH, 27'h5555555);
      set_idling(0, 0);
      random_items(30, 10);

      req_push <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("generations_cellular_automaton_3d test passed");
      else
         $display("generations_cellular_automaton_3d test failed");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gca_pkg.sv
hw/rtl/gca_front.sv
hw/rtl/gca_rsp_fifo.sv
hw/rtl/gca_back.sv
hw/rtl/generations_cellular_automaton_3d.sv
hw/rtl/gca_checker.sv
tb/tb_generations_cellular_automaton_3d.sv
